@@ src/spq_pkg.sv @@
// Shared constants, types and helper functions for the sorted priority queue.
// No dependencies; imported by every module of the block.
package spq_pkg;

   localparam int CAPACITY = 16;
   localparam int COUNT_W  = $clog2(CAPACITY + 1);
   localparam int DATA_W   = 16;
   localparam int REQ_W    = 40;
   localparam int RSP_W    = 40;

   localparam logic [1:0] CSR_ORDER_MODE_ADDR = 2'd0;

   localparam logic [1:0] ACT_PUSH = 2'd0;
   localparam logic [1:0] ACT_POP  = 2'd1;
   localparam logic [1:0] ACT_TOP  = 2'd2;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   localparam logic [1:0] MODE_LT = 2'd0;
   localparam logic [1:0] MODE_LE = 2'd1;
   localparam logic [1:0] MODE_GT = 2'd2;
   localparam logic [1:0] MODE_GE = 2'd3;

   typedef struct packed {
      logic load;
      logic execute;
   } spq_cmd_type;

   function automatic logic rel_holds(input logic [1:0] mode,
                                      input logic signed [DATA_W-1:0] a,
                                      input logic signed [DATA_W-1:0] b);
      logic r;
      case (mode)
         MODE_LT: r = a < b;
         MODE_LE: r = a <= b;
         MODE_GT: r = a > b;
         MODE_GE: r = a >= b;
         default: r = 1'b0;
      endcase
      return r;
   endfunction

endpackage

@@ src/spq_ctrl.sv @@
// Controller of the sorted priority queue: two-state sequencer and result handshake.
// Depends on spq_pkg.
module spq_ctrl import spq_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output spq_cmd_type  cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EXEC = 1'b1;

   logic state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;

   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign cmd.load    = req_tvalid && req_tready;
   assign cmd.execute = (state_ff == ST_EXEC);
   assign rsp_tvalid  = rsp_valid_ff;

   always_comb begin
      case (state_ff)
         ST_IDLE: state_in = cmd.load ? ST_EXEC : ST_IDLE;
         ST_EXEC: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.execute) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ src/spq_dpath.sv @@
// Datapath of the sorted priority queue: entry cells with parallel compare-and-shift,
// item latch and result register. Depends on spq_pkg.
module spq_dpath import spq_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  spq_cmd_type        cmd,
   input  logic [1:0]         order_mode,
   input  logic [REQ_W-1:0]   req_tdata,
   output logic [RSP_W-1:0]   rsp_tdata
);

   logic [DATA_W-1:0]  value_ff [CAPACITY];
   logic [DATA_W-1:0]  value_in [CAPACITY];
   logic [DATA_W-1:0]  prio_ff  [CAPACITY];
   logic [DATA_W-1:0]  prio_in  [CAPACITY];
   logic [COUNT_W-1:0] count_ff, count_in;

   logic [1:0]         act_ff;
   logic [DATA_W-1:0]  item_val_ff;
   logic [DATA_W-1:0]  item_pri_ff;

   logic [DATA_W-1:0]  out_val_ff, out_val_in;
   logic [DATA_W-1:0]  out_pri_ff, out_pri_in;
   logic [1:0]         out_st_ff, out_st_in;
   logic               out_empty_ff, out_empty_in;

   logic [CAPACITY-1:0] hit;
   logic [CAPACITY-1:0] at_or_after;
   logic                is_empty;
   logic                is_full;

   assign is_empty   = (count_ff == '0);
   assign is_full    = (count_ff == COUNT_W'(CAPACITY));

   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         hit[i] = ((COUNT_W'(i) < count_ff) &&
                   rel_holds(order_mode, item_pri_ff, prio_ff[i])) ||
                  (COUNT_W'(i) == count_ff);
      end
      at_or_after[0] = hit[0];
      for (int i = 1; i < CAPACITY; i++) begin
         at_or_after[i] = at_or_after[i-1] | hit[i];
      end
   end

   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         value_in[i] = value_ff[i];
         prio_in[i]  = prio_ff[i];
      end
      count_in     = count_ff;
      out_val_in   = '0;
      out_pri_in   = '0;
      out_st_in    = ST_OK;
      case (act_ff)
         ACT_PUSH: begin
            if (is_full) begin
               out_st_in = ST_FULL;
            end else begin
               for (int i = 0; i < CAPACITY; i++) begin
                  if (at_or_after[i]) begin
                     if (i == 0 || !at_or_after[(i == 0) ? 0 : i-1]) begin
                        value_in[i] = item_val_ff;
                        prio_in[i]  = item_pri_ff;
                     end else begin
                        value_in[i] = value_ff[(i == 0) ? 0 : i-1];
                        prio_in[i]  = prio_ff[(i == 0) ? 0 : i-1];
                     end
                  end
               end
               count_in = count_ff + 1'b1;
            end
         end
         ACT_POP, ACT_TOP: begin
            if (is_empty) begin
               out_st_in = ST_EMPTY;
            end else begin
               out_val_in = value_ff[0];
               out_pri_in = prio_ff[0];
               if (act_ff == ACT_POP) begin
                  for (int i = 0; i < CAPACITY - 1; i++) begin
                     value_in[i] = value_ff[i+1];
                     prio_in[i]  = prio_ff[i+1];
                  end
                  count_in = count_ff - 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
      out_empty_in = (count_in == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.execute) begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         act_ff      <= req_tdata[1:0];
         item_val_ff <= req_tdata[17:2];
         item_pri_ff <= req_tdata[33:18];
      end
      if (cmd.execute) begin
         for (int i = 0; i < CAPACITY; i++) begin
            value_ff[i] <= value_in[i];
            prio_ff[i]  <= prio_in[i];
         end
         out_val_ff   <= out_val_in;
         out_pri_ff   <= out_pri_in;
         out_st_ff    <= out_st_in;
         out_empty_ff <= out_empty_in;
      end
   end

   assign rsp_tdata = {5'd0, out_empty_ff, out_st_ff, out_pri_ff, out_val_ff};

endmodule

@@ src/sorted_priority_queue_core.sv @@
// Top level of the sorted priority queue: configuration register and glue between
// controller and datapath. Depends on spq_pkg, spq_ctrl and spq_dpath.
//
// The queue keeps up to 16 (value, priority) entries sorted with the head in slot 0.
// Each request transfer (push, pop or top) yields exactly one response transfer.
// A request is first accepted and latched, then executed: on a push every entry
// cell compares its priority with the new one in parallel and the whole list
// shifts into place. No new request is taken while one is executing, nor while the
// response side does not keep up. The ordering relation (order_mode at address 0)
// must only be written while no request is in flight.
module sorted_priority_queue_core import spq_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   // Fields from bit 0: action[1:0], item_value[17:2], item_priority[33:18], zero pad.
   input  logic [REQ_W-1:0]   req_tdata,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   // Fields from bit 0: out_value[15:0], out_priority[31:16], status[33:32],
   // now_empty[34], zero pad.
   output logic [RSP_W-1:0]   rsp_tdata,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [1:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   logic [1:0]   order_mode_ff;
   logic         csr_write;
   spq_cmd_type  cmd;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                       (csr_paddr == CSR_ORDER_MODE_ADDR);
   assign csr_prdata = {30'd0, order_mode_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         order_mode_ff <= MODE_LT;
      end else if (csr_write) begin
         order_mode_ff <= csr_pwdata[1:0];
      end
   end

   spq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   spq_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .order_mode (order_mode_ff),
      .req_tdata  (req_tdata),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

@@ tb/sorted_priority_queue_checker.sv @@
`timescale 1ns / 1ps
// Checker for the sorted priority queue: keeps its own sorted list, predicts every
// response from the observed request and register transfers and compares field by field.
// Depends on spq_pkg for widths, capacity, action, status and ordering codes.
module sorted_priority_queue_checker import spq_pkg::*; #(
   parameter logic [1:0] MODE_ADDR = 2'd0
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   input  logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,
   input  logic             rsp_tvalid,
   input  logic             rsp_tready,
   input  logic [RSP_W-1:0] rsp_tdata,
   input  logic             csr_psel,
   input  logic             csr_penable,
   input  logic             csr_pwrite,
   input  logic [1:0]       csr_paddr,
   input  logic [31:0]      csr_pwdata,
   input  logic             csr_pready,
   output int               fail_count,
   output int               pending_count
);

   typedef struct packed {
      logic                     now_empty;
      logic [1:0]               status;
      logic signed [DATA_W-1:0] out_priority;
      logic [DATA_W-1:0]        out_value;
   } queue_result_type;

   logic [DATA_W-1:0]        held_value [CAPACITY];
   logic signed [DATA_W-1:0] held_priority [CAPACITY];
   int                       held_count;
   logic [1:0]               order_mode;
   queue_result_type         predicted_results [$];

   function automatic logic ranks_ahead(input logic signed [DATA_W-1:0] incoming,
                                        input logic signed [DATA_W-1:0] stored);
      logic ahead;
      case (order_mode)
         MODE_LT: ahead = incoming < stored;
         MODE_LE: ahead = incoming <= stored;
         MODE_GT: ahead = incoming > stored;
         default: ahead = incoming >= stored;
      endcase
      return ahead;
   endfunction

   task automatic predict_result(input logic [1:0] action,
                                 input logic [DATA_W-1:0] value,
                                 input logic signed [DATA_W-1:0] prio);
      queue_result_type r;
      int slot;
      r = '0;
      case (action)
         ACT_PUSH: begin
            if (held_count >= CAPACITY) begin
               r.status = ST_FULL;
            end else begin
               slot = held_count;
               for (int i = held_count - 1; i >= 0; i--)
                  if (ranks_ahead(prio, held_priority[i])) slot = i;
               for (int i = held_count; i > slot; i--) begin
                  held_value[i]    = held_value[i-1];
                  held_priority[i] = held_priority[i-1];
               end
               held_value[slot]    = value;
               held_priority[slot] = prio;
               held_count++;
            end
         end
         ACT_POP, ACT_TOP: begin
            if (held_count == 0) begin
               r.status = ST_EMPTY;
            end else begin
               r.out_value    = held_value[0];
               r.out_priority = held_priority[0];
               if (action == ACT_POP) begin
                  for (int i = 0; i + 1 < held_count; i++) begin
                     held_value[i]    = held_value[i+1];
                     held_priority[i] = held_priority[i+1];
                  end
                  held_count--;
               end
            end
         end
         default: ;
      endcase
      r.now_empty = (held_count == 0);
      predicted_results.push_back(r);
   endtask

   function automatic void compare_field(input string name,
                                         input logic [DATA_W-1:0] want,
                                         input logic [DATA_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         fail_count++;
      end
   endfunction

   task automatic check_result(input logic [RSP_W-1:0] word);
      queue_result_type want;
      if (predicted_results.size() == 0) begin
         $display("%0t: response transfer %h arrived with none expected, expected nothing",
                  $time, word);
         fail_count++;
      end else begin
         want = predicted_results.pop_front();
         compare_field("out_value", want.out_value, word[15:0]);
         compare_field("out_priority", want.out_priority, word[31:16]);
         compare_field("status", DATA_W'(want.status), DATA_W'(word[33:32]));
         compare_field("now_empty", DATA_W'(want.now_empty), DATA_W'(word[34]));
         compare_field("padding", '0, DATA_W'(word[RSP_W-1:35]));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         fail_count = 0;
         held_count = 0;
         order_mode = MODE_LT;
         predicted_results.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_paddr == MODE_ADDR)
            order_mode = csr_pwdata[1:0];
         if (req_tvalid && req_tready)
            predict_result(req_tdata[1:0], req_tdata[17:2], req_tdata[33:18]);
         if (rsp_tvalid && rsp_tready)
            check_result(rsp_tdata);
      end
      pending_count = predicted_results.size();
   end

endmodule

@@ tb/sorted_priority_queue_core_tb.sv @@
`timescale 1ns / 1ps
// Top of the sorted priority queue testbench: clock, reset, register writes, request
// stimulus with random idling on both channels, and the final verdict.
// Depends on spq_pkg, sorted_priority_queue_core and sorted_priority_queue_checker.
module sorted_priority_queue_core_tb;
   import spq_pkg::*;

   localparam logic [1:0] ORDER_MODE_ADDR = 2'd0;
   localparam logic [1:0] ACT_IGNORED     = 2'd3;
   localparam int         CYCLE_LIMIT     = 200000;
   localparam int         PHASES          = 8;
   localparam int         ITEMS_PER_PHASE = 56;

   logic             clock;
   logic             reset;
   logic             req_tvalid;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;
   logic             csr_psel;
   logic             csr_penable;
   logic             csr_pwrite;
   logic [1:0]       csr_paddr;
   logic [31:0]      csr_pwdata;
   logic [31:0]      csr_prdata;
   logic             csr_pready;
   int               fail_count;
   int               pending_count;
   int               send_idle_pct;
   int               stall_pct;
   int               cycle_count = 0;

   sorted_priority_queue_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   sorted_priority_queue_checker #(.MODE_ADDR(ORDER_MODE_ADDR)) queue_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_pready    (csr_pready),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   always @(negedge clock)
      rsp_tready <= ($urandom_range(99) >= stall_pct);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("sorted_priority_queue_core verification failed");
         $finish;
      end
   end

   task automatic send_request(input logic [1:0] action, input logic [15:0] value,
                               input logic [15:0] prio);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'b0, prio, value, action};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
   endtask

   task automatic write_order_mode(input logic [1:0] mode);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= ORDER_MODE_ADDR;
      csr_pwdata  <= {30'b0, mode};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // Priorities lean on a narrow band so that equal priorities meet often.
   task automatic send_random_item(input int push_pct);
      int         roll;
      logic [1:0] action;
      logic [15:0] prio;
      roll = $urandom_range(99);
      if (roll < 3) action = ACT_IGNORED;
      else if (roll < 3 + push_pct) action = ACT_PUSH;
      else if (roll < 15 + push_pct) action = ACT_TOP;
      else action = ACT_POP;
      roll = $urandom_range(99);
      if (roll < 40) begin
         prio = 16'($urandom_range(4));
         prio = prio - 16'd2;
      end else if (roll < 55) begin
         case ($urandom_range(3))
            0: prio = 16'h8000;
            1: prio = 16'h7FFF;
            2: prio = 16'h0000;
            default: prio = 16'hFFFF;
         endcase
      end else begin
         prio = 16'($urandom());
      end
      send_request(action, 16'($urandom()), prio);
   endtask

   initial begin
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      csr_psel      = 1'b0;
      csr_penable   = 1'b0;
      csr_pwrite    = 1'b0;
      csr_paddr     = '0;
      csr_pwdata    = '0;
      send_idle_pct = 0;
      stall_pct     = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      write_order_mode(MODE_LT);
      send_request(ACT_POP, 16'hFFFF, 16'hFFFF);
      send_request(ACT_TOP, 16'h0000, 16'h0000);
      send_request(ACT_IGNORED, 16'hA5A5, 16'h5A5A);
      send_request(ACT_PUSH, 16'h0000, 16'h8000);
      send_request(ACT_PUSH, 16'hFFFF, 16'h7FFF);
      send_request(ACT_PUSH, 16'h1234, 16'h0000);
      send_request(ACT_PUSH, 16'h5678, 16'h0000);
      send_request(ACT_PUSH, 16'h9ABC, 16'hFFFF);
      send_request(ACT_PUSH, 16'h0F0F, 16'h8000);
      send_request(ACT_IGNORED, 16'hFFFF, 16'hFFFF);
      send_request(ACT_TOP, 16'h0000, 16'h0000);
      repeat (6) send_request(ACT_POP, 16'h0000, 16'h0000);
      send_request(ACT_POP, 16'h0000, 16'h0000);
      send_request(ACT_TOP, 16'hFFFF, 16'hFFFF);

      for (int phase = 0; phase < PHASES; phase++) begin
         wait_for_drain();
         case (phase % 4)
            0: write_order_mode(MODE_LT);
            1: write_order_mode(MODE_GE);
            2: write_order_mode(MODE_LE);
            default: write_order_mode(MODE_GT);
         endcase
         case ((phase / 2) % 4)
            0: begin
               send_idle_pct = 0;
               stall_pct     = 0;
            end
            1: begin
               send_idle_pct = 74;
               stall_pct     = 0;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct     = 74;
            end
            default: begin
               send_idle_pct = 12;
               stall_pct     = 12;
            end
         endcase
         // Alternate filling and draining stretches so the queue runs full and empty.
         for (int n = 0; n < ITEMS_PER_PHASE; n++)
            send_random_item(((n / 28) % 2 == 0) ? 80 : 20);
      end
      wait_for_drain();
      repeat (20) @(posedge clock);

      if (fail_count == 0 && pending_count == 0)
         $display("sorted_priority_queue_core verification clean");
      else
         $display("sorted_priority_queue_core verification failed");
      $finish;
   end

endmodule
